FILE: hdl/elg_pkg.sv
`default_nettype none

package elg_pkg;

  // Configuration register map
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS    = 2'd0,
    REG_GENERATOR  = 2'd1,
    REG_PUBLIC_KEY = 2'd2
  } cfg_reg_t;

  // Register values after reset
  localparam int MODULUS_RESET    = 83;
  localparam int GENERATOR_RESET  = 4;
  localparam int PUBLIC_KEY_RESET = 1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } ctrl_state_t;

  // Which power is being formed
  typedef enum logic [1:0] {
    PH_C1,
    PH_GM,
    PH_PKR
  } phase_t;

  // Modular multiplication to issue next
  typedef enum logic [1:0] {
    OP_BASE,
    OP_MUL,
    OP_SQR,
    OP_FINAL
  } op_t;

endpackage

`default_nettype wire

FILE: hdl/elg_in_if.sv
`default_nettype none

interface elg_in_if #(
  parameter int EXP_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [EXP_BITS-1:0] message_exp;
  logic [EXP_BITS-1:0] random_exp;

  modport source (output valid, output message_exp, output random_exp, input ready);
  modport sink   (input valid, input message_exp, input random_exp, output ready);
endinterface

`default_nettype wire

FILE: hdl/elg_out_if.sv
`default_nettype none

interface elg_out_if #(
  parameter int MOD_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [MOD_BITS-1:0] cipher_first;
  logic [MOD_BITS-1:0] cipher_second;

  modport source (output valid, output cipher_first, output cipher_second, input ready);
  modport sink   (input valid, input cipher_first, input cipher_second, output ready);
endinterface

`default_nettype wire

FILE: hdl/elgamal_exponential_encrypt_top.sv
// Exponential ElGamal encryption: each input beat (message_exp m, random_exp r) gives one
// output beat with cipher_first = g^r mod p and cipher_second = g^m * pk^r mod p, where p, g
// and pk are the configuration registers modulus, generator and public_key (reset 83, 4, 1;
// write them only while no beat is in flight). All arithmetic runs on one shift-and-add
// modular multiplier. An item costs three base reductions, one product per set exponent
// bit, EXP_BITS-1 squarings per power and one closing product; a clear exponent bit skips
// its product. A modulus below two gives zeros for both outputs without using the
// multiplier. Input ready is low while an item is worked on; one finished result may wait
// in the output register while the next item is taken.
`default_nettype none

module elgamal_exponential_encrypt_top #(
  parameter int EXP_BITS = 16,
  parameter int MOD_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  elg_in_if.sink                                in_if,
  elg_out_if.source                             out_if,
  input  wire logic                             cfg_we,
  input  wire logic [elg_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [MOD_BITS-1:0]              cfg_wdata
);

  logic [MOD_BITS-1:0] modulus_r, modulus_nxt;
  logic [MOD_BITS-1:0] generator_r, generator_nxt;
  logic [MOD_BITS-1:0] public_key_r, public_key_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [MOD_BITS-1:0] out_c1_r, out_c1_nxt;
  logic [MOD_BITS-1:0] out_c2_r, out_c2_nxt;

  logic                out_free;
  logic                res_load;
  logic [MOD_BITS-1:0] res_c1;
  logic [MOD_BITS-1:0] res_c2;

  logic                mm_start;
  logic [MOD_BITS-1:0] mm_a;
  logic [MOD_BITS-1:0] mm_b;
  logic [MOD_BITS-1:0] mm_n;
  logic                mm_done;
  logic [MOD_BITS-1:0] mm_res;

  // Configuration registers
  always_comb begin
    modulus_nxt    = modulus_r;
    generator_nxt  = generator_r;
    public_key_nxt = public_key_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        elg_pkg::REG_MODULUS:    modulus_nxt    = cfg_wdata;
        elg_pkg::REG_GENERATOR:  generator_nxt  = cfg_wdata;
        elg_pkg::REG_PUBLIC_KEY: public_key_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= MOD_BITS'(elg_pkg::MODULUS_RESET);
      generator_r  <= MOD_BITS'(elg_pkg::GENERATOR_RESET);
      public_key_r <= MOD_BITS'(elg_pkg::PUBLIC_KEY_RESET);
    end else begin
      modulus_r    <= modulus_nxt;
      generator_r  <= generator_nxt;
      public_key_r <= public_key_nxt;
    end
  end

  // Sequencer
  elg_ctrl #(
    .EXP_BITS (EXP_BITS),
    .MOD_BITS (MOD_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .message_exp   (in_if.message_exp),
    .random_exp    (in_if.random_exp),
    .modulus       (modulus_r),
    .generator     (generator_r),
    .public_key    (public_key_r),
    .out_free      (out_free),
    .res_load      (res_load),
    .cipher_first  (res_c1),
    .cipher_second (res_c2),
    .mm_start      (mm_start),
    .mm_a          (mm_a),
    .mm_b          (mm_b),
    .mm_n          (mm_n),
    .mm_done       (mm_done),
    .mm_res        (mm_res)
  );

  // Shared modular multiplier
  elg_mulmod #(
    .MOD_BITS (MOD_BITS)
  ) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .a     (mm_a),
    .b     (mm_b),
    .n     (mm_n),
    .done  (mm_done),
    .res   (mm_res)
  );

  // Output register
  assign out_free = !out_valid_r || out_if.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_c1_nxt    = out_c1_r;
    out_c2_nxt    = out_c2_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_c1_nxt    = res_c1;
      out_c2_nxt    = res_c2;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_c1_r <= out_c1_nxt;
    out_c2_r <= out_c2_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.cipher_first  = out_c1_r;
  assign out_if.cipher_second = out_c2_r;

endmodule

`default_nettype wire

FILE: hdl/elg_mulmod.sv
`default_nettype none

// Interleaved shift-and-add modular multiplier, one bit of b per cycle, MSB first.
// Needs a < n; b may be any value. Result valid in the cycle done is high.
module elg_mulmod #(
  parameter int MOD_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [MOD_BITS-1:0] a,
  input  wire logic [MOD_BITS-1:0] b,
  input  wire logic [MOD_BITS-1:0] n,
  output logic                     done,
  output logic [MOD_BITS-1:0]      res
);

  localparam int CW = $clog2(MOD_BITS);
  localparam int TW = MOD_BITS + 2;

  logic                busy_r, busy_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [MOD_BITS-1:0] acc_r, acc_nxt;
  logic [MOD_BITS-1:0] a_r, a_nxt;
  logic [MOD_BITS-1:0] b_r, b_nxt;
  logic [MOD_BITS-1:0] n_r, n_nxt;

  logic [TW-1:0] sum;
  logic [TW-1:0] n1;
  logic [TW-1:0] n2;
  logic [TW-1:0] red;
  logic          last;

  // 2*acc + bit*a stays below 3n; take off n or 2n
  always_comb begin
    n1  = {2'b00, n_r};
    n2  = {1'b0, n_r, 1'b0};
    sum = {1'b0, acc_r, 1'b0} + (b_r[MOD_BITS-1] ? {2'b00, a_r} : '0);
    priority if (sum >= n2) begin
      red = sum - n2;
    end else if (sum >= n1) begin
      red = sum - n1;
    end else begin
      red = sum;
    end
  end

  assign last = (cnt_r == CW'(MOD_BITS - 1));
  assign done = busy_r && last;
  assign res  = red[MOD_BITS-1:0];

  // Step sequencing
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    n_nxt    = n_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      n_nxt    = n;
    end else if (busy_r) begin
      acc_nxt = red[MOD_BITS-1:0];
      b_nxt   = {b_r[MOD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r + CW'(1);
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    n_r   <= n_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/elg_ctrl.sv
`default_nettype none

// Sequencer: three LSB-first square-and-multiply powers and one closing
// product, all on the shared modular multiplier.
module elg_ctrl #(
  parameter int EXP_BITS = 16,
  parameter int MOD_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [EXP_BITS-1:0] message_exp,
  input  wire logic [EXP_BITS-1:0] random_exp,
  input  wire logic [MOD_BITS-1:0] modulus,
  input  wire logic [MOD_BITS-1:0] generator,
  input  wire logic [MOD_BITS-1:0] public_key,
  input  wire logic                out_free,
  output logic                     res_load,
  output logic [MOD_BITS-1:0]      cipher_first,
  output logic [MOD_BITS-1:0]      cipher_second,
  output logic                     mm_start,
  output logic [MOD_BITS-1:0]      mm_a,
  output logic [MOD_BITS-1:0]      mm_b,
  output logic [MOD_BITS-1:0]      mm_n,
  input  wire logic                mm_done,
  input  wire logic [MOD_BITS-1:0] mm_res
);

  localparam int BW = $clog2(EXP_BITS);

  elg_pkg::ctrl_state_t state_r, state_nxt;
  elg_pkg::phase_t      phase_r, phase_nxt;
  elg_pkg::op_t         op_r, op_nxt;
  logic [BW-1:0]        bit_r, bit_nxt;

  logic [EXP_BITS-1:0] m_r, m_nxt;
  logic [EXP_BITS-1:0] r_r, r_nxt;
  logic [MOD_BITS-1:0] acc_r, acc_nxt;
  logic [MOD_BITS-1:0] sq_r, sq_nxt;
  logic [MOD_BITS-1:0] gm_r, gm_nxt;
  logic [MOD_BITS-1:0] c1_r, c1_nxt;
  logic [MOD_BITS-1:0] c2_r, c2_nxt;

  logic                n_small;
  logic [EXP_BITS-1:0] exp_sel;
  logic [MOD_BITS-1:0] base_sel;
  logic                ebit;
  logic                last_bit;
  logic                skip;
  logic                step_done;
  logic [MOD_BITS-1:0] new_acc;

  // Operand selection for the current power
  assign n_small   = (modulus < MOD_BITS'(2));
  assign exp_sel   = (phase_r == elg_pkg::PH_GM) ? m_r : r_r;
  assign base_sel  = (phase_r == elg_pkg::PH_PKR) ? public_key : generator;
  assign ebit      = exp_sel[bit_r];
  assign last_bit  = (bit_r == BW'(EXP_BITS - 1));
  assign skip      = (state_r == elg_pkg::ST_ISSUE) && (op_r == elg_pkg::OP_MUL) && !ebit;
  assign step_done = ((state_r == elg_pkg::ST_WAIT) && mm_done) || skip;
  assign new_acc   = skip ? acc_r : mm_res;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      elg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = n_small ? elg_pkg::ST_DONE : elg_pkg::ST_ISSUE;
        end
      end
      elg_pkg::ST_ISSUE: begin
        if (!skip) begin
          state_nxt = elg_pkg::ST_WAIT;
        end
      end
      elg_pkg::ST_WAIT: begin
        if (mm_done) begin
          state_nxt = (op_r == elg_pkg::OP_FINAL) ? elg_pkg::ST_DONE : elg_pkg::ST_ISSUE;
        end
      end
      elg_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = elg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = elg_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = (state_r == elg_pkg::ST_IDLE);
    res_load = (state_r == elg_pkg::ST_DONE) && out_free;
    mm_start = (state_r == elg_pkg::ST_ISSUE) && !skip;
    mm_n     = modulus;
    unique case (op_r)
      elg_pkg::OP_BASE: begin
        mm_a = MOD_BITS'(1);
        mm_b = base_sel;
      end
      elg_pkg::OP_MUL: begin
        mm_a = acc_r;
        mm_b = sq_r;
      end
      elg_pkg::OP_SQR: begin
        mm_a = sq_r;
        mm_b = sq_r;
      end
      elg_pkg::OP_FINAL: begin
        mm_a = gm_r;
        mm_b = acc_r;
      end
      default: begin
        mm_a = '0;
        mm_b = '0;
      end
    endcase
  end

  assign cipher_first  = c1_r;
  assign cipher_second = c2_r;

  // Working registers
  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    bit_nxt   = bit_r;
    m_nxt     = m_r;
    r_nxt     = r_r;
    acc_nxt   = acc_r;
    sq_nxt    = sq_r;
    gm_nxt    = gm_r;
    c1_nxt    = c1_r;
    c2_nxt    = c2_r;
    if ((state_r == elg_pkg::ST_IDLE) && in_valid) begin
      m_nxt     = message_exp;
      r_nxt     = random_exp;
      phase_nxt = elg_pkg::PH_C1;
      op_nxt    = elg_pkg::OP_BASE;
      bit_nxt   = '0;
      acc_nxt   = MOD_BITS'(1);
      if (n_small) begin
        c1_nxt = '0;
        c2_nxt = '0;
      end
    end else if (step_done) begin
      unique case (op_r)
        elg_pkg::OP_BASE: begin
          sq_nxt = mm_res;
          op_nxt = elg_pkg::OP_MUL;
        end
        elg_pkg::OP_MUL: begin
          acc_nxt = new_acc;
          if (last_bit) begin
            bit_nxt = '0;
            unique case (phase_r)
              elg_pkg::PH_C1: begin
                c1_nxt    = new_acc;
                acc_nxt   = MOD_BITS'(1);
                phase_nxt = elg_pkg::PH_GM;
                op_nxt    = elg_pkg::OP_BASE;
              end
              elg_pkg::PH_GM: begin
                gm_nxt    = new_acc;
                acc_nxt   = MOD_BITS'(1);
                phase_nxt = elg_pkg::PH_PKR;
                op_nxt    = elg_pkg::OP_BASE;
              end
              elg_pkg::PH_PKR: begin
                op_nxt = elg_pkg::OP_FINAL;
              end
              default: begin
                op_nxt = elg_pkg::OP_FINAL;
              end
            endcase
          end else begin
            op_nxt = elg_pkg::OP_SQR;
          end
        end
        elg_pkg::OP_SQR: begin
          sq_nxt  = mm_res;
          op_nxt  = elg_pkg::OP_MUL;
          bit_nxt = bit_r + BW'(1);
        end
        elg_pkg::OP_FINAL: begin
          c2_nxt = mm_res;
        end
        default: begin
          op_nxt = elg_pkg::OP_FINAL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= elg_pkg::ST_IDLE;
      phase_r <= elg_pkg::PH_C1;
      op_r    <= elg_pkg::OP_BASE;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    r_r   <= r_nxt;
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    gm_r  <= gm_nxt;
    c1_r  <= c1_nxt;
    c2_r  <= c2_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/elg_checker.sv
`default_nettype none

module elg_checker #(
  parameter int MOD_BITS = 16
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [MOD_BITS-1:0] cipher_first,
  input wire logic [MOD_BITS-1:0] cipher_second
);

  // A taken beat closes the input until the item is finished
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready after a beat was taken");

  // A result only appears out of a busy period
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without an item being worked on");

  // A pending result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(cipher_first) && $stable(cipher_second)))
    else $error("result payload changed while stalled");

endmodule

bind elgamal_exponential_encrypt_top elg_checker #(
  .MOD_BITS (MOD_BITS)
) u_elg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .cipher_first  (out_if.cipher_first),
  .cipher_second (out_if.cipher_second)
);

`default_nettype wire
